@@ src/b64d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and character helpers for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] ChPad   = 8'h3D; // '='
  localparam logic [7:0] ChPlus  = 8'h2B; // '+'
  localparam logic [7:0] ChSlash = 8'h2F; // '/'
  localparam logic [7:0] ChMinus = 8'h2D; // '-'
  localparam logic [7:0] ChUnder = 8'h5F; // '_'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    KindByte    = 2'd0,
    KindValid   = 2'd1,
    KindInvalid = 2'd2
  } kind_e;

  // One queued job: up to three results, the last of which carries final_kind.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [1:0]                 count;
    kind_e                      final_kind;
  } job_t;

  // Sextet lookup: bit 6 set means the character is a symbol of the alphabet.
  function automatic logic [6:0] sym_lookup(input logic [7:0] c, input logic alt_alpha);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (alt_alpha && c == ChMinus) begin
      r = {1'b1, 6'd62};
    end else if (alt_alpha && c == ChUnder) begin
      r = {1'b1, 6'd63};
    end else if (!alt_alpha && c == ChPlus) begin
      r = {1'b1, 6'd62};
    end else if (!alt_alpha && c == ChSlash) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

@@ src/b64d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the quad state and queues result jobs.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       alt_alpha_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output job_t       q_job_o
);

  logic [17:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;
  logic        pqd_q, pqd_d;
  logic        err_q, err_d;

  logic        fire;
  logic [6:0]  sym;
  logic [23:0] triple;
  logic [23:0] tail;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign sym        = sym_lookup(char_code_i, alt_alpha_i);
  assign tail       = {acc_q, 6'd0};

  always_comb begin
    logic [5:0] v;
    logic       take;
    acc_d    = acc_q;
    pos_d    = pos_q;
    pad_d    = pad_q;
    pqd_d    = pqd_q;
    err_d    = err_q;
    q_push_o = 1'b0;
    q_job_o  = '0;
    v        = 6'd0;
    take     = 1'b0;
    triple   = {acc_q, 6'd0};

    if (fire) begin
      if (end_of_input_i) begin
        q_push_o = 1'b1;
        if (err_q || pos_q == 2'd1) begin
          q_job_o.count      = 2'd1;
          q_job_o.final_kind = KindInvalid;
        end else begin
          q_job_o.final_kind = KindValid;
          if (pos_q == 2'd2) begin
            q_job_o.bytes[0] = acc_q[11:4];
            q_job_o.count    = 2'd2;
          end else if (pos_q == 2'd3) begin
            q_job_o.bytes[0] = tail[23:16];
            q_job_o.bytes[1] = tail[15:8];
            q_job_o.count    = pad_q[0] ? 2'd2 : 2'd3;
          end else begin
            q_job_o.count = 2'd1;
          end
        end
        acc_d = '0;
        pos_d = '0;
        pad_d = '0;
        pqd_d = 1'b0;
        err_d = 1'b0;
      end else if (!is_space(char_code_i) && !err_q) begin
        if (pqd_q) begin
          err_d = 1'b1;
        end else if (char_code_i == ChPad) begin
          if (pos_q < 2'd2) begin
            err_d = 1'b1;
          end else begin
            pad_d = pad_q + 2'd1;
            take  = 1'b1;
          end
        end else if (!sym[6] || pad_q != 2'd0) begin
          err_d = 1'b1;
        end else begin
          v    = sym[5:0];
          take = 1'b1;
        end

        if (take) begin
          if (pos_q != 2'd3) begin
            acc_d = {acc_q[11:0], v};
            pos_d = pos_q + 2'd1;
          end else begin
            // Quad complete: one byte fewer for each pad, never fewer than one.
            triple             = {acc_q, v};
            q_push_o           = 1'b1;
            q_job_o.bytes[0]   = triple[23:16];
            q_job_o.bytes[1]   = triple[15:8];
            q_job_o.bytes[2]   = triple[7:0];
            q_job_o.final_kind = KindByte;
            q_job_o.count      = (pad_d == 2'd0) ? 2'd3 : (pad_d == 2'd1) ? 2'd2 : 2'd1;
            pqd_d              = pqd_q || (pad_d != 2'd0);
            pad_d              = '0;
            pos_d              = '0;
            acc_d              = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
      pad_q <= '0;
      pqd_q <= 1'b0;
      err_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
      pad_q <= pad_d;
      pqd_q <= pqd_d;
      err_q <= err_d;
    end
  end

endmodule

@@ src/b64d_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == (QueuePtrW + 1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/b64d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Walks the head job and presents its results one item at a time.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output kind_e      item_kind_o,
  output logic       last_of_run_o
);

  logic [1:0] idx_q;
  logic       fire;

  assign out_valid_o   = !q_empty_i;
  assign fire          = out_valid_o && out_ready_i;
  assign last_of_run_o = (idx_q == q_head_i.count - 2'd1);
  assign q_pop_o       = fire && last_of_run_o;

  always_comb begin
    if (last_of_run_o && q_head_i.final_kind != KindByte) begin
      out_byte_o  = 8'd0;
      item_kind_o = q_head_i.final_kind;
    end else begin
      out_byte_o  = q_head_i.bytes[idx_q];
      item_kind_o = KindByte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= last_of_run_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

@@ src/base64_lenient_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_lenient_stream_decoder_unit
// Lenient streaming base64 decoder, standard or URL-safe alphabet.
// ----------------------------------------------------------------------------
// One character is accepted per cycle on the slave stream while the job
// queue is not full; tuser high marks an end-of-message item instead.
// Whitespace is skipped, every fourth symbol queues up to three decoded
// bytes, and an end item queues any bytes of a short final group followed
// by a status item (valid or invalid). The master stream gives one result
// item per cycle while the consumer is ready. A two-entry job queue separates
// the two sides, so characters keep flowing while results wait to be taken,
// until the queue is full. tlast marks the final result caused by one input
// item. After an invalid status the consumer should drop the bytes of that
// message. The alphabet register is written through the cfg channel, which
// is always ready, and should only change while idle.
// ----------------------------------------------------------------------------
module base64_lenient_stream_decoder_unit import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: bit 0 selects the URL-safe alphabet.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  // Character stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] end_of_input
  // Result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] item_kind
  output logic       m_axis_tlast    // last result of one input item
);

  logic  alt_alpha_q;
  logic  q_push, q_full, q_pop, q_empty;
  job_t  q_job, q_head;
  kind_e kind;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_alpha_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alt_alpha_q <= cfg_data_i;
    end
  end

  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .alt_alpha_i    (alt_alpha_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .char_code_i    (s_axis_tdata),
    .end_of_input_i (s_axis_tuser),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (q_job)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .item_kind_o   (kind),
    .last_of_run_o (m_axis_tlast)
  );

  assign m_axis_tuser = kind;

endmodule

@@ dv/tb_base64_lenient_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_lenient_stream_decoder_unit
// Self-checking testbench for the lenient streaming base64 decoder.
// ----------------------------------------------------------------------------
// Character items are fed from a backlog by a clocked driver. A clocked
// monitor decodes every accepted item with its own model of the decoder and
// checks each result item against the oldest awaited one. Both stream sides
// idle in random bursts, except in the last phase. The alphabet register is
// changed between phases, only once the decoder has gone quiet.
// ----------------------------------------------------------------------------
module tb_base64_lenient_stream_decoder_unit;
  import b64d_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted   = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i    = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] char_code
  logic       s_axis_tuser  = 1'b0;   // [0] end_of_input
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [1:0] m_axis_tuser;           // [1:0] item_kind
  logic       m_axis_tlast;

  // Decoder state as the testbench sees it.
  logic        alphabet_url = 1'b0;
  logic [17:0] dec_acc      = '0;
  logic [1:0]  dec_pos      = '0;
  logic [1:0]  dec_pads     = '0;
  logic        dec_padded   = 1'b0;
  logic        dec_err      = 1'b0;

  char_item_t  char_backlog[$];
  result_t     awaited_results[$];
  char_item_t  head;
  logic        char_taken = 1'b0;
  logic        calm       = 1'b0;
  int unsigned src_gap    = 0;
  int unsigned sink_gap   = 0;

  int unsigned items_queued   = 0;
  int unsigned items_taken    = 0;
  int unsigned messages       = 0;
  int unsigned bytes_checked  = 0;
  int unsigned valid_ends     = 0;
  int unsigned invalid_ends   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  base64_lenient_stream_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Bit 6 flags a symbol of the current alphabet, bits 5:0 its value.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch, input logic url);
    if (ch >= 8'h41 && ch <= 8'h5A) return {1'b1, 6'(ch - 8'h41)};
    if (ch >= 8'h61 && ch <= 8'h7A) return {1'b1, 6'(ch - 8'h61 + 8'd26)};
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, 6'(ch - 8'h30 + 8'd52)};
    if (ch == (url ? ChMinus : ChPlus)) return {1'b1, 6'd62};
    if (ch == (url ? ChUnder : ChSlash)) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic logic [7:0] char_of_sextet(input logic [5:0] v, input logic url);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return url ? ChMinus : ChPlus;
    return url ? ChUnder : ChSlash;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
  endfunction

  task automatic push_result(input logic [7:0] data, input kind_e kind, input logic last);
    awaited_results.push_back(result_t'{data, kind, last});
  endtask

  // Works out the result items that one accepted item causes.
  task automatic decode_char(input logic [7:0] ch, input logic eom);
    logic [6:0]  sym;
    logic [5:0]  v;
    logic [23:0] triple;
    int unsigned nbytes;
    if (eom) begin
      if (dec_err || dec_pos == 2'd1) begin
        push_result(8'h00, KindInvalid, 1'b1);
      end else begin
        // A short final group is padded implicitly; its low bits are ignored.
        if (dec_pos == 2'd2) begin
          push_result(dec_acc[11:4], KindByte, 1'b0);
        end else if (dec_pos == 2'd3) begin
          triple = {dec_acc, 6'd0};
          push_result(triple[23:16], KindByte, 1'b0);
          if (dec_pads == 2'd0) push_result(triple[15:8], KindByte, 1'b0);
        end
        push_result(8'h00, KindValid, 1'b1);
      end
      dec_acc    = '0;
      dec_pos    = '0;
      dec_pads   = '0;
      dec_padded = 1'b0;
      dec_err    = 1'b0;
      return;
    end
    if (is_blank(ch) || dec_err) return;
    if (dec_padded) begin
      dec_err = 1'b1;
      return;
    end
    if (ch == ChPad) begin
      if (dec_pos < 2'd2) begin
        dec_err = 1'b1;
        return;
      end
      dec_pads++;
      v = 6'd0;
    end else begin
      sym = sextet_of(ch, alphabet_url);
      if (!sym[6] || dec_pads != 2'd0) begin
        dec_err = 1'b1;
        return;
      end
      v = sym[5:0];
    end
    if (dec_pos != 2'd3) begin
      dec_acc = {dec_acc[11:0], v};
      dec_pos++;
      return;
    end
    triple = {dec_acc, v};
    nbytes = 3 - dec_pads;
    for (int i = 0; i < nbytes; i++) begin
      push_result(triple[23 - 8 * i -: 8], KindByte, i == nbytes - 1);
    end
    if (dec_pads != 2'd0) dec_padded = 1'b1;
    dec_acc  = '0;
    dec_pos  = '0;
    dec_pads = '0;
  endtask

  task automatic queue_char(input logic [7:0] ch, input logic eom);
    char_backlog.push_back(char_item_t'{ch, eom});
    items_queued++;
  endtask

  task automatic queue_end();
    queue_char(8'($urandom_range(0, 255)), 1'b1);
    messages++;
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ChSpace : ChTab + 8'(k);
  endfunction

  function automatic logic [7:0] symbol_char();
    return char_of_sextet(6'($urandom_range(0, 63)), alphabet_url);
  endfunction

  // Mostly symbols, pads and blanks; the odd character of the other alphabet.
  function automatic logic [7:0] mixed_char();
    case ($urandom_range(0, 5))
      0: return ChPad;
      1: return blank_char();
      2: begin
        if (alphabet_url) return $urandom_range(0, 1) ? ChPlus : ChSlash;
        return $urandom_range(0, 1) ? ChMinus : ChUnder;
      end
      default: return symbol_char();
    endcase
  endfunction

  // One message: usually well formed with random content, sometimes broken,
  // sometimes plain noise.
  task automatic queue_message();
    logic [7:0]  msg[$];
    int unsigned style;
    int unsigned nquads;
    int unsigned tail;
    int unsigned spot;
    style = $urandom_range(0, 9);
    if (style == 8) begin
      repeat ($urandom_range(0, 9)) msg.push_back(8'($urandom_range(0, 255)));
    end else if (style == 9) begin
      repeat ($urandom_range(0, 9)) msg.push_back(mixed_char());
    end else begin
      nquads = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
      repeat (4 * nquads) msg.push_back(symbol_char());
      // Tail: none, two symbols and two pads, three and one pad, or an
      // unpadded group of two or three.
      tail = $urandom_range(0, 4);
      if (tail != 0) begin
        repeat ((tail == 1 || tail == 3) ? 2 : 3) msg.push_back(symbol_char());
        if (tail == 1) repeat (2) msg.push_back(ChPad);
        if (tail == 2) msg.push_back(ChPad);
      end
      if (style == 7) begin
        spot = (msg.size() == 0) ? 0 : $urandom_range(0, msg.size() - 1);
        case ($urandom_range(0, 3))
          0: if (msg.size() != 0) msg[spot] = 8'($urandom_range(0, 255));
          1: if (msg.size() != 0) msg[spot] = ChPad; else msg.push_back(ChPad);
          2: if (msg.size() != 0) msg.delete(spot);
          default: repeat ($urandom_range(1, 4)) msg.push_back(symbol_char());
        endcase
      end
    end
    foreach (msg[i]) begin
      if ($urandom_range(0, 9) == 0) queue_char(blank_char(), 1'b0);
      queue_char(msg[i], 1'b0);
    end
    queue_end();
  endtask

  task automatic write_alphabet(input logic url);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= url;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    alphabet_url = url;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every item is taken and every result has come, then lets the
  // decoder run out, since blanks and rejected characters give no result.
  task automatic settle();
    while (items_taken != items_queued || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Character driver.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || char_taken)) begin
      char_taken = 1'b0;
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (char_backlog.size() != 0) begin
        head = char_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= head.ch;
        s_axis_tuser  <= head.eom;
        if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure.
  always @(negedge clk_i) begin
    if (sink_gap != 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predicts on accepted characters, checks accepted results.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata, s_axis_tuser);
        items_taken++;
        char_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %02h kind %0d with none awaited",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, awaited %02h", m_axis_tdata, want.data));
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("item_kind %0d, awaited %0d", m_axis_tuser, want.kind));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, awaited %b", m_axis_tlast, want.last));
          case (want.kind)
            KindByte:  bytes_checked++;
            KindValid: valid_ends++;
            default:   invalid_ends++;
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results awaited",
               cycle_count, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_alphabet(1'b0);

    // Directed: empty message, the two top symbols with a blank and a one-pad
    // quad, a symbol after a padded quad, an unpadded group of three with
    // non-zero spare bits, a lone symbol, a pad in the second position
    // followed by 0xFF under the sticky error, and a NUL character.
    queue_end();
    queue_string("/+9z");
    queue_char(ChCr, 1'b0);
    queue_string("TWE=");
    queue_end();
    queue_string("TQ==A");
    queue_end();
    queue_string("TWF");
    queue_end();
    queue_string("T");
    queue_end();
    queue_string("Q=");
    queue_char(8'hFF, 1'b0);
    queue_end();
    queue_char(8'h00, 1'b0);
    queue_end();
    settle();

    write_alphabet(1'b1);
    while (items_queued < 125) queue_message();
    settle();

    write_alphabet(1'b0);
    while (items_queued < 240) queue_message();
    settle();

    // Last stretch at full rate on both sides.
    write_alphabet(1'b1);
    calm = 1'b1;
    while (items_queued < 350) queue_message();
    settle();

    $display("Fed %0d character items in %0d messages under both alphabets.",
             items_taken, messages);
    $display("Checked %0d decoded bytes, %0d valid and %0d invalid message ends.",
             bytes_checked, valid_ends, invalid_ends);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
